/* rtl/core/dtm_pkg.sv */
package dtm_pkg;

  localparam int SAMPLE_W      = 24;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int INTENS_W      = 8;
  localparam int STATUS_W      = 2;
  localparam int QUOT_W        = 8;
  localparam int DIV_STEP_W    = 3;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DEPTH_BITS_DEF = 24;

  localparam logic [CFG_W-1:0] FRAME_DIM_RST = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALL_READ   = 2'd2;

  localparam int GAIN   = 223;
  localparam int OFFSET = 32;

  typedef struct packed {
    logic                  load;
    logic                  sub;
    logic                  mul;
    logic                  div;
    logic [DIV_STEP_W-1:0] div_bit;
    logic                  emit;
    logic [STATUS_W-1:0]   status;
  } dtm_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic all_read;
    logic out_busy;
  } dtm_stat_t;

endpackage

/* rtl/core/dtm_ctrl.sv */
module dtm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_mode,
  output logic             in_tready,
  input  dtm_pkg::dtm_stat_t stat,
  output dtm_pkg::dtm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                               state_r, state_nxt;
  logic [dtm_pkg::DIV_STEP_W-1:0]       div_bit_r, div_bit_nxt;
  logic [dtm_pkg::STATUS_W-1:0]         status_r, status_nxt;
  logic                                 accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    div_bit_nxt = div_bit_r;
    status_nxt  = status_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            cmd.load = 1'b1;
          end else if (!stat.frame_full) begin
            status_nxt = dtm_pkg::ST_NOT_LOADED;
            state_nxt  = S_EMIT;
          end else if (stat.all_read) begin
            status_nxt = dtm_pkg::ST_ALL_READ;
            state_nxt  = S_EMIT;
          end else begin
            status_nxt = dtm_pkg::ST_OK;
            state_nxt  = S_SUB;
          end
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        div_bit_nxt = '1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div     = 1'b1;
        cmd.div_bit = div_bit_r;
        div_bit_nxt = div_bit_r - 1'b1;
        if (div_bit_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_bit_r <= '0;
      status_r  <= dtm_pkg::ST_OK;
    end else begin
      state_r   <= state_nxt;
      div_bit_r <= div_bit_nxt;
      status_r  <= status_nxt;
    end
  end

endmodule

/* rtl/core/dtm_datapath.sv */
module dtm_datapath #(
  parameter int MAX_WIDTH  = dtm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtm_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtm_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dtm_pkg::dtm_cmd_t             cmd,
  output dtm_pkg::dtm_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [dtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [dtm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [dtm_pkg::INTENS_W-1:0]  out_intensity,
  output logic [dtm_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  localparam int PIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int CNT_W  = $clog2(PIX + 1);
  localparam int NUM_W  = DEPTH_BITS + dtm_pkg::QUOT_W;
  localparam int PROD_W = 2 * dtm_pkg::CFG_W;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MASK = {DEPTH_BITS{1'b1}};

  function automatic logic [dtm_pkg::CFG_W-1:0] clamp_dim(
    input logic [dtm_pkg::CFG_W-1:0] v,
    input int                        top
  );
    logic [dtm_pkg::CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = dtm_pkg::CFG_W'(1);
    end else if (int'(v) > top) begin
      r = dtm_pkg::CFG_W'(top);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] pixels_of(
    input logic [dtm_pkg::CFG_W-1:0] w,
    input logic [dtm_pkg::CFG_W-1:0] h
  );
    logic [PROD_W-1:0] p;
    p = PROD_W'(w) * PROD_W'(h);
    return CNT_W'(p);
  endfunction

  // frame size
  logic [dtm_pkg::CFG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0]          total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_dim(dtm_pkg::FRAME_DIM_RST, MAX_WIDTH);
      height_r <= clamp_dim(dtm_pkg::FRAME_DIM_RST, MAX_HEIGHT);
      total_r  <= pixels_of(clamp_dim(dtm_pkg::FRAME_DIM_RST, MAX_WIDTH),
                            clamp_dim(dtm_pkg::FRAME_DIM_RST, MAX_HEIGHT));
    end else if (cfg_we) begin
      case (cfg_index)
        dtm_pkg::REG_FRAME_WIDTH: begin
          width_r <= clamp_dim(cfg_wdata, MAX_WIDTH);
          total_r <= pixels_of(clamp_dim(cfg_wdata, MAX_WIDTH), height_r);
        end
        dtm_pkg::REG_FRAME_HEIGHT: begin
          height_r <= clamp_dim(cfg_wdata, MAX_HEIGHT);
          total_r  <= pixels_of(width_r, clamp_dim(cfg_wdata, MAX_HEIGHT));
        end
        default: begin
          width_r <= width_r;
        end
      endcase
    end
  end

  // frame counters and running min / max
  logic [CNT_W-1:0]                  load_count_r, load_count_nxt;
  logic [CNT_W-1:0]                  read_count_r, read_count_nxt;
  logic [DEPTH_BITS-1:0]             min_r, min_nxt, max_r, max_nxt;
  logic [CNT_W-1:0]                  base_cnt;
  logic [DEPTH_BITS-1:0]             base_min, base_max;
  logic [dtm_pkg::SAMPLE_W+DEPTH_BITS-1:0] sample_ext;
  logic [DEPTH_BITS-1:0]             sample;
  logic                              full;

  assign sample_ext = {{DEPTH_BITS{1'b0}}, in_sample};
  assign sample     = sample_ext[DEPTH_BITS-1:0];
  assign full       = (load_count_r >= total_r);
  assign base_cnt   = full ? '0 : load_count_r;
  assign base_min   = full ? DEPTH_MASK : min_r;
  assign base_max   = full ? '0 : max_r;

  always_comb begin
    load_count_nxt = load_count_r;
    read_count_nxt = read_count_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    if (cmd.load) begin
      load_count_nxt = base_cnt + CNT_W'(1);
      min_nxt        = base_min;
      max_nxt        = base_max;
      if (full) begin
        read_count_nxt = '0;
      end
      if (sample != '0) begin
        if (sample < base_min) begin
          min_nxt = sample;
        end
        if (sample > base_max) begin
          max_nxt = sample;
        end
      end
    end else if (cmd.emit && cmd.status == dtm_pkg::ST_OK) begin
      read_count_nxt = read_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      load_count_r <= '0;
      read_count_r <= '0;
      min_r        <= DEPTH_MASK;
      max_r        <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      read_count_r <= read_count_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
    end
  end

  // depth frame store
  logic [DEPTH_BITS-1:0] store_mem [PIX];
  logic [DEPTH_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[base_cnt[ADDR_W-1:0]] <= sample;
    end
    rd_data_r <= store_mem[read_count_r[ADDR_W-1:0]];
  end

  // normalise: subtract, scale, then restoring divide one quotient bit a step
  logic [DEPTH_BITS-1:0]       diff_r, span_r;
  logic                        zero_r, flat_r;
  logic [NUM_W-1:0]            rem_r, shifted;
  logic [dtm_pkg::QUOT_W-1:0]  quot_r, quot_sat;
  logic [dtm_pkg::INTENS_W-1:0] mapped;

  assign shifted = NUM_W'(span_r) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      diff_r <= rd_data_r - min_r;
      span_r <= max_r - min_r;
      zero_r <= (rd_data_r == '0);
      flat_r <= (max_r <= min_r) || (rd_data_r < min_r);
    end
    if (cmd.mul) begin
      rem_r  <= NUM_W'(diff_r) * NUM_W'(dtm_pkg::GAIN);
      quot_r <= '0;
    end else if (cmd.div) begin
      if (rem_r >= shifted) begin
        rem_r                <= rem_r - shifted;
        quot_r[cmd.div_bit]  <= 1'b1;
      end
    end
  end

  assign quot_sat = (quot_r > dtm_pkg::QUOT_W'(dtm_pkg::GAIN)) ?
                    dtm_pkg::QUOT_W'(dtm_pkg::GAIN) : quot_r;

  always_comb begin
    if (zero_r) begin
      mapped = '0;
    end else if (flat_r) begin
      mapped = dtm_pkg::INTENS_W'(dtm_pkg::OFFSET);
    end else begin
      mapped = quot_sat + dtm_pkg::INTENS_W'(dtm_pkg::OFFSET);
    end
  end

  // result register
  logic                          out_valid_r;
  logic [dtm_pkg::INTENS_W-1:0]  out_intensity_r;
  logic [dtm_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      if (cmd.status == dtm_pkg::ST_OK) begin
        out_intensity_r <= mapped;
        out_last_r      <= ((read_count_r + CNT_W'(1)) == total_r);
      end else begin
        out_intensity_r <= '0;
        out_last_r      <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_intensity = out_intensity_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  assign stat.frame_full = full;
  assign stat.all_read   = (read_count_r >= total_r);
  assign stat.out_busy   = out_valid_r && !out_tready;

endmodule

/* rtl/core/depth_tone_map.sv */
// channel   direction  content
// in_       slave      tuser: mode; tdata: depth_sample
// out_      master     tdata: intensity; tuser: status; tlast: last_pixel
// cfg_      write      index 0 frame_width, index 1 frame_height
//
// a load beat is taken every cycle while no readout is under way; a readout runs
// subtract, scale, the 8-step restoring divider and emit before the next accept,
// or only emit when it reports a status code. rst_n is synchronous; the store
// needs no clearing. the result register lets loads continue while a pixel waits
// on out_tready; a readout holds in its last step until that register is free.
module depth_tone_map #(
  parameter int MAX_WIDTH  = dtm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtm_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtm_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dtm_pkg::SAMPLE_W-1:0]  in_tdata,   // depth_sample
  input  logic                          in_tuser,   // mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dtm_pkg::INTENS_W-1:0]  out_tdata,  // intensity
  output logic [dtm_pkg::STATUS_W-1:0]  out_tuser,  // status
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [dtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtm_pkg::CFG_W-1:0]     cfg_wdata
);

  dtm_pkg::dtm_cmd_t  cmd;
  dtm_pkg::dtm_stat_t stat;

  dtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_sample     (in_tdata),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_intensity (out_tdata),
    .out_status    (out_tuser),
    .out_last      (out_tlast)
  );

endmodule

/* tb/sv/depth_tone_map_tb.sv */
`timescale 1ns / 100ps

module depth_tone_map_tb;
  import dtm_pkg::*;

  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_READ = 1'b1;
  localparam int ITEM_GOAL = 1900;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {FILL_SPREAD, FILL_FLAT, FILL_NARROW, FILL_SPARSE, FILL_EXTREME} fill_t;

  typedef struct packed {
    logic [INTENS_W-1:0] level;
    logic [STATUS_W-1:0] code;
    logic                last;
  } pixel_t;

  class gray_tracker;
    bit [SAMPLE_W-1:0] depth_mem [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
    bit [16:0]         loaded;
    bit [16:0]         read_out;
    bit [SAMPLE_W-1:0] lo;
    bit [SAMPLE_W-1:0] hi;
    bit [CFG_W-1:0]    width_reg;
    bit [CFG_W-1:0]    height_reg;
    pixel_t            pending_pixels[$];
    int unsigned       errors;

    function new();
      width_reg  = FRAME_DIM_RST;
      height_reg = FRAME_DIM_RST;
      errors     = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      loaded   = '0;
      read_out = '0;
      lo       = '1;
      hi       = '0;
    endfunction

    function int unsigned clamp_dim(bit [CFG_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, MAX_HEIGHT_DEF);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      restart_frame();
    endfunction

    function bit [INTENS_W-1:0] gray_level(bit [SAMPLE_W-1:0] d);
      longint unsigned span;
      longint unsigned q;
      if (d == 0) return '0;
      if (hi <= lo || d < lo) return INTENS_W'(OFFSET);
      span = hi - lo;
      q = (longint'(GAIN) * (d - lo)) / span;
      if (q > GAIN) q = GAIN;
      return INTENS_W'(q + OFFSET);
    endfunction

    function void take_beat(bit mode, bit [SAMPLE_W-1:0] sample);
      pixel_t      p;
      int unsigned total;
      total = frame_pixels();
      if (mode == MODE_LOAD) begin
        if (loaded >= total) restart_frame();
        depth_mem[loaded[15:0]] = sample;
        if (sample != 0) begin
          if (sample < lo) lo = sample;
          if (sample > hi) hi = sample;
        end
        loaded++;
        return;
      end
      p = '{level: '0, code: ST_OK, last: 1'b0};
      if (loaded < total) begin
        p.code = ST_NOT_LOADED;
      end else if (read_out >= total) begin
        p.code = ST_ALL_READ;
      end else begin
        p.level = gray_level(depth_mem[read_out[15:0]]);
        read_out++;
        p.last = (read_out == total);
      end
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(logic [INTENS_W-1:0] level, logic [STATUS_W-1:0] code,
                              logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual intensity %0d status %0d last %0d",
                 $time, level, code, last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (want.level !== level) begin
        $display("%0t: intensity expected %0d actual %0d", $time, want.level, level);
        errors++;
      end
      if (want.code !== code) begin
        $display("%0t: status expected %0d actual %0d", $time, want.code, code);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last_pixel expected %0d actual %0d", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [INTENS_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]  out_tuser;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  gray_tracker board;
  bit          idle_on = 1'b0;
  int unsigned sent = 0;

  depth_tone_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit [SAMPLE_W-1:0] pick_depth(fill_t kind, bit [SAMPLE_W-1:0] base);
    case (kind)
      FILL_SPREAD: return ($urandom_range(0, 7) == 0) ? '0 : SAMPLE_W'($urandom);
      FILL_FLAT:   return ($urandom_range(0, 5) == 0) ? '0 : base;
      FILL_NARROW: return base + SAMPLE_W'($urandom_range(0, 15));
      FILL_SPARSE: return ($urandom_range(0, 3) != 0) ? '0 : SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return SAMPLE_W'(1);
          2: return '1;
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input bit mode, input bit [SAMPLE_W-1:0] sample);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    board.take_beat(mode, sample);
    sent++;
  endtask

  // drain all pixels, then let any load in flight finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(REG_FRAME_WIDTH, w);
    board.set_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic run_frames(input int count);
    int unsigned       total;
    int unsigned       cut;
    fill_t             kind;
    bit [SAMPLE_W-1:0] base;
    repeat (count) begin
      total = board.frame_pixels();
      kind  = fill_t'($urandom_range(0, 4));
      base  = SAMPLE_W'($urandom_range(1, 24'hFFFFF0));
      idle_on = (sent + 200 < ITEM_GOAL) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 11) == 0) send_beat(MODE_READ, SAMPLE_W'($urandom));
        send_beat(MODE_LOAD, pick_depth(kind, base));
      end
      // now and then a new frame starts before the readout is done
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
      for (int i = 0; i < cut; i++) send_beat(MODE_READ, SAMPLE_W'($urandom));
      if (cut == total) repeat ($urandom_range(0, 2)) send_beat(MODE_READ, SAMPLE_W'($urandom));
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_pixel(out_tdata, out_tuser, out_tlast);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // directed: 2x2 frame
    set_size(9'd2, 9'd2);
    send_beat(MODE_READ, '0);
    send_beat(MODE_LOAD, '0);
    send_beat(MODE_READ, '1);
    send_beat(MODE_LOAD, '1);
    send_beat(MODE_LOAD, 24'h000001);
    send_beat(MODE_LOAD, 24'h800000);
    repeat (5) send_beat(MODE_READ, '0);
    // new frame after a complete one, all non-zero samples equal
    send_beat(MODE_LOAD, '0);
    repeat (3) send_beat(MODE_LOAD, 24'h123456);
    repeat (5) send_beat(MODE_READ, 24'hABCDEF);

    set_size(9'd0, 9'd0);
    run_frames(3);
    set_size(9'd511, 9'd1);
    run_frames(1);
    set_size(9'd1, 9'd256);
    run_frames(1);
    while (sent < ITEM_GOAL) begin
      set_size(($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 9)),
               ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 9)));
      run_frames($urandom_range(1, 3));
    end

    idle_on = 1'b0;
    settle();
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout, %0d pixels still outstanding", board.pending_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
